/* rtl/baoab_pkg.sv */
package baoab_pkg;

	// Atom table sizing
	localparam int ATOM_COUNT = 1024;
	localparam int ATOM_W     = 10;
	localparam int MEM_DEPTH  = (ATOM_COUNT < (1 << ATOM_W)) ? ATOM_COUNT : (1 << ATOM_W);
	localparam int MEM_AW     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	// Pipeline: items read the stores in stage 1 and write back in stage 16
	localparam int LAST_STAGE = 16;

	// Request kinds (tuser)
	localparam logic [2:0] REQ_LOAD_VM  = 3'd0;
	localparam logic [2:0] REQ_LOAD_POS = 3'd1;
	localparam logic [2:0] REQ_PHASE1   = 3'd2;
	localparam logic [2:0] REQ_PHASE2   = 3'd3;
	localparam logic [2:0] REQ_PHASE3   = 3'd4;
	localparam logic [2:0] REQ_PHASE4   = 3'd5;

	// Register indexes
	localparam logic [2:0] REG_HALF_STEP     = 3'd0;
	localparam logic [2:0] REG_INV_HALF_STEP = 3'd1;
	localparam logic [2:0] REG_VEL_SCALE     = 3'd2;
	localparam logic [2:0] REG_NOISE_SCALE   = 3'd3;

	localparam logic [31:0] RST_HALF_STEP     = 32'd2147484;
	localparam logic [31:0] RST_INV_HALF_STEP = 32'd131072000;
	localparam logic [31:0] RST_VEL_SCALE     = 32'hFFFF_FFFF;
	localparam logic [31:0] RST_NOISE_SCALE   = 32'd0;

	typedef logic signed [47:0] vec48_t;

	// Product scaling of the multiplier unit
	typedef enum logic [2:0] {
		SH16 = 3'b001,
		SH32 = 3'b010,
		SH56 = 3'b100
	} shift_t;

	typedef struct packed {
		logic [31:0] half_step;
		logic [31:0] inv_half_step;
		logic [31:0] vel_scale;
		logic [31:0] noise_scale;
	} cfg_t;

	// Per-item operation flags, decoded once in stage 1
	typedef struct packed {
		logic kick;
		logic friction;
		logic active;
		logic load_v;
		logic load_p;
		logic upd_pos;
		logic upd_delta;
		logic in_range;
	} op_ctl_t;

	function automatic vec48_t sat48(input logic signed [63:0] x);
		if (x[63:47] == '0 || x[63:47] == '1)
			return x[47:0];
		else if (x[63])
			return 48'sh8000_0000_0000;
		else
			return 48'sh7FFF_FFFF_FFFF;
	endfunction

	function automatic vec48_t add_sat48(input vec48_t a, input vec48_t b);
		logic signed [48:0] s;
		s = 49'(a) + 49'(b);
		if (s[48] != s[47])
			return s[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
		return s[47:0];
	endfunction

endpackage

/* rtl/baoab_mul.sv */
// Signed x unsigned 64-bit multiply, floor scaling and 48-bit saturation.
// Four stages: partial products, middle sum, full sum, shift and clamp.
module baoab_mul import baoab_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [63:0] a,
	input  logic        [63:0] b,
	input  shift_t             sh,
	output vec48_t             y
);

	logic signed [31:0]  a_hi;
	logic        [31:0]  a_lo;
	logic        [63:0]  p00_s1, p01_s1, p00_s2;
	logic signed [64:0]  p10_s1, p11_s1, p11_s2;
	logic signed [65:0]  mid_s2;
	logic signed [128:0] sum_s3;
	logic signed [128:0] shifted;
	shift_t              sh_s1, sh_s2, sh_s3;
	vec48_t              y_s4;

	assign a_hi = a[63:32];
	assign a_lo = a[31:0];

	// 32x32 partial products, then sums
	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= 64'(a_lo) * 64'(b[31:0]);
			p01_s1 <= 64'(a_lo) * 64'(b[63:32]);
			p10_s1 <= 65'(a_hi) * 65'($signed({1'b0, b[31:0]}));
			p11_s1 <= 65'(a_hi) * 65'($signed({1'b0, b[63:32]}));
			sh_s1  <= sh;

			p00_s2 <= p00_s1;
			p11_s2 <= p11_s1;
			mid_s2 <= 66'($signed({1'b0, p01_s1})) + 66'(p10_s1);
			sh_s2  <= sh_s1;

			sum_s3 <= (129'(p11_s2) <<< 64) + (129'(mid_s2) <<< 32)
				+ 129'($signed({1'b0, p00_s2}));
			sh_s3  <= sh_s2;

			y_s4 <= (shifted[128:47] == '0 || shifted[128:47] == '1) ? shifted[47:0] :
				(shifted[128] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF);
		end
	end

	// Floor scaling is an arithmetic shift of the exact product
	always_comb begin
		case (sh_s3)
			SH16:    shifted = sum_s3 >>> 16;
			SH32:    shifted = sum_s3 >>> 32;
			default: shifted = sum_s3 >>> 56;
		endcase
	end

	assign y = y_s4;

endmodule

/* rtl/baoab_isqrt.sv */
// Integer square root of the 32-bit inverse mass, four result bits per stage.
module baoab_isqrt import baoab_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] x,
	output logic [15:0] root
);

	localparam int STAGES = 4;
	localparam int STEPS  = 4;

	logic [31:0] x_q [STAGES];
	logic [31:0] r_q [STAGES];

	function automatic logic [63:0] isqrt_steps(input logic [31:0] xi, input logic [31:0] ri,
		input int first);
		logic [31:0] xv, rv, bv;
		xv = xi;
		rv = ri;
		for (int j = 0; j < STEPS; j++) begin
			bv = 32'(1) << (30 - 2 * (first + j));
			if (xv >= rv + bv) begin
				xv = xv - (rv + bv);
				rv = (rv >> 1) + bv;
			end else begin
				rv = rv >> 1;
			end
		end
		return {xv, rv};
	endfunction

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic [31:0] xi, ri;
		logic [63:0] nx;
		if (g == 0) begin : g_first
			assign xi = x;
			assign ri = '0;
		end else begin : g_next
			assign xi = x_q[g-1];
			assign ri = r_q[g-1];
		end
		assign nx = isqrt_steps(xi, ri, g * STEPS);
		always_ff @(posedge clk) begin
			if (en) begin
				x_q[g] <= nx[63:32];
				r_q[g] <= nx[31:0];
			end
		end
	end

	assign root = r_q[STAGES-1][15:0];

endmodule

/* rtl/baoab_lane.sv */
// One axis of the update: its three stores and the kick, friction and drift chain.
module baoab_lane import baoab_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [MEM_AW-1:0]   rd_atom,
	input  logic signed [63:0]  vec_in,
	input  logic signed [15:0]  nz_in,
	input  op_ctl_t             ctl_s1,
	input  op_ctl_t             ctl_s2,
	input  op_ctl_t             ctl_s11,
	input  op_ctl_t             ctl_s16,
	input  cfg_t                cfg,
	input  logic [63:0]         hm_s2,
	input  logic [47:0]         amp_s7,
	input  logic                wr_en,
	input  logic [MEM_AW-1:0]   wr_atom,
	output vec48_t              vel_out,
	output vec48_t              pos_out,
	output vec48_t              dlt_out
);

	vec48_t vel_mem [MEM_DEPTH];
	vec48_t pos_mem [MEM_DEPTH];
	vec48_t dlt_mem [MEM_DEPTH];

	vec48_t             v_s1, p_s1, od_s1, d_s1, psum_s1;
	logic signed [63:0] vec_s1, vec_s2;
	logic signed [15:0] nz_s1;
	logic signed [48:0] diff_s2;

	vec48_t             vorig_q [2:6];
	vec48_t             vkeep_q [2:16];
	vec48_t             pnew_q  [2:16];
	vec48_t             od_q    [2:16];
	logic signed [15:0] nz_q    [2:7];
	vec48_t             v1_q    [7:11];
	vec48_t             vf_q    [12:16];

	logic signed [63:0] m1_a;
	logic        [63:0] m1_b;
	shift_t             m1_sh;
	vec48_t             t1, t2, t3, t4;
	vec48_t             v_new, p_new, d_new;

	// Store write-back and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			vel_mem[wr_atom] <= v_new;
			pos_mem[wr_atom] <= p_new;
			dlt_mem[wr_atom] <= d_new;
		end
		if (en) begin
			v_s1  <= vel_mem[rd_atom];
			p_s1  <= pos_mem[rd_atom];
			od_s1 <= dlt_mem[rd_atom];
		end
	end

	assign d_s1    = sat48(vec_s1);
	assign psum_s1 = add_sat48(p_s1, d_s1);

	// Operand staging and delay lines
	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1 <= vec_in;
			nz_s1  <= nz_in;

			vec_s2     <= vec_s1;
			diff_s2    <= 49'(d_s1) - 49'(od_s1);
			vorig_q[2] <= v_s1;
			vkeep_q[2] <= ctl_s1.load_v ? d_s1 : v_s1;
			pnew_q[2]  <= ctl_s1.load_p ? d_s1 : (ctl_s1.upd_pos ? psum_s1 : p_s1);
			od_q[2]    <= od_s1;
			nz_q[2]    <= nz_s1;

			for (int k = 3; k <= 6; k++) vorig_q[k] <= vorig_q[k-1];
			for (int k = 3; k <= 16; k++) begin
				vkeep_q[k] <= vkeep_q[k-1];
				pnew_q[k]  <= pnew_q[k-1];
				od_q[k]    <= od_q[k-1];
			end
			for (int k = 3; k <= 7; k++) nz_q[k] <= nz_q[k-1];

			v1_q[7] <= add_sat48(vorig_q[6], t1);
			for (int k = 8; k <= 11; k++) v1_q[k] <= v1_q[k-1];

			vf_q[12] <= ctl_s11.friction ? add_sat48(t2, t3) : v1_q[11];
			for (int k = 13; k <= 16; k++) vf_q[k] <= vf_q[k-1];
		end
	end

	// Kick from force or constraint correction
	assign m1_a  = ctl_s2.kick ? vec_s2 : 64'(diff_s2);
	assign m1_b  = ctl_s2.kick ? hm_s2 : 64'(cfg.inv_half_step);
	assign m1_sh = ctl_s2.kick ? SH56 : SH16;

	baoab_mul u_mul_kick (
		.clk (clk), .en (en), .a (m1_a), .b (m1_b), .sh (m1_sh), .y (t1)
	);

	// Friction decay and thermal noise
	baoab_mul u_mul_fric (
		.clk (clk), .en (en), .a (64'(v1_q[7])), .b (64'(cfg.vel_scale)), .sh (SH32), .y (t2)
	);

	baoab_mul u_mul_noise (
		.clk (clk), .en (en), .a (64'(nz_q[7])), .b (64'(amp_s7)), .sh (SH16), .y (t3)
	);

	// Drift delta
	baoab_mul u_mul_drift (
		.clk (clk), .en (en), .a (64'(vf_q[12])), .b (64'(cfg.half_step)), .sh (SH32), .y (t4)
	);

	// Final state of the atom
	assign v_new = ctl_s16.active ? vf_q[16] : vkeep_q[16];
	assign p_new = pnew_q[16];
	assign d_new = ctl_s16.upd_delta ? t4 : od_q[16];

	assign vel_out = ctl_s16.in_range ? v_new : '0;
	assign pos_out = ctl_s16.in_range ? p_new : '0;
	assign dlt_out = ctl_s16.in_range ? d_new : '0;

endmodule

/* rtl/langevin_baoab_atom_update_unit.sv */
// BAOAB Langevin atom update. Takes one item per clock when the output side does not stall
// and returns one result per item. Each item reads the per-atom velocity, position and
// delta stores in stage 1 and writes them back in stage 16, so an item whose atom matches
// one still in those 16 stages waits at s_tready until that one has written back; items
// for distinct atoms stream at one per cycle. The x, y and z axes run in three parallel
// lanes, each with four pipelined 64x64 multipliers; an output register merges the lanes,
// and a low m_tready with a full output register stalls the pipeline and s_tready. Configuration
// registers may be written only while no transaction is in flight; cfg_ready is always high.
module langevin_baoab_atom_update_unit import baoab_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	// tdata: atom_index[9:0], vec_x[73:10], vec_y[137:74], vec_z[201:138],
	//        inv_mass[233:202], noise_x[249:234], noise_y[265:250], noise_z[281:266]
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [287:0] s_tdata,
	// tuser: req_type[2:0]
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata: out_atom[9:0], vel_x/y/z[153:10], pos_x/y/z[297:154], delta_x/y/z[441:298]
	output logic [447:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	cfg_t               cfg_q;
	logic               en, hit, accept, in_range_in;
	logic [ATOM_W-1:0]  s_atom;
	logic [2:0]         req_s1;
	logic [31:0]        m_s1;
	logic [15:0]        root_s5;
	logic [63:0]        hm_s2;
	logic [47:0]        amp_s6, amp_s7;
	op_ctl_t            ctl_s1;
	op_ctl_t            ctl_q   [2:LAST_STAGE];
	logic               valid_q [1:LAST_STAGE];
	logic [ATOM_W-1:0]  atom_q  [1:LAST_STAGE];
	logic [31:0]        mass_mem [MEM_DEPTH];
	logic               m_tvalid_q;
	logic [447:0]       m_tdata_q;
	logic               wr_en;
	logic signed [63:0] vec_in [3];
	logic signed [15:0] nz_in  [3];
	vec48_t             vel_o [3];
	vec48_t             pos_o [3];
	vec48_t             dlt_o [3];

	assign s_atom      = s_tdata[9:0];
	assign in_range_in = (32'(s_atom) < ATOM_COUNT);
	assign vec_in[0]   = s_tdata[73:10];
	assign vec_in[1]   = s_tdata[137:74];
	assign vec_in[2]   = s_tdata[201:138];
	assign nz_in[0]    = s_tdata[249:234];
	assign nz_in[1]    = s_tdata[265:250];
	assign nz_in[2]    = s_tdata[281:266];

	// Configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_step     <= RST_HALF_STEP;
			cfg_q.inv_half_step <= RST_INV_HALF_STEP;
			cfg_q.vel_scale     <= RST_VEL_SCALE;
			cfg_q.noise_scale   <= RST_NOISE_SCALE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HALF_STEP:     cfg_q.half_step     <= cfg_data;
				REG_INV_HALF_STEP: cfg_q.inv_half_step <= cfg_data;
				REG_VEL_SCALE:     cfg_q.vel_scale     <= cfg_data;
				REG_NOISE_SCALE:   cfg_q.noise_scale   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Whole pipeline advances unless the output register is full and stalled
	assign en = !m_tvalid_q || m_tready;

	// Same-atom check against every stage up to and including write-back
	always_comb begin
		hit = 1'b0;
		for (int k = 1; k <= LAST_STAGE; k++)
			if (valid_q[k] && atom_q[k] == s_atom) hit = 1'b1;
	end

	assign s_tready = en && !hit;
	assign accept   = s_tvalid && s_tready;

	// Inverse mass store: set by accepted load requests; safe as the atom is not in flight
	always_ff @(posedge clk) begin
		if (accept && s_tuser == REQ_LOAD_VM && in_range_in)
			mass_mem[s_atom[MEM_AW-1:0]] <= s_tdata[233:202];
		if (en)
			m_s1 <= mass_mem[s_atom[MEM_AW-1:0]];
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAST_STAGE; k++) valid_q[k] <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			valid_q[1] <= accept;
			for (int k = 2; k <= LAST_STAGE; k++) valid_q[k] <= valid_q[k-1];
			m_tvalid_q <= valid_q[LAST_STAGE];
		end
	end

	// Operation decode in stage 1
	always_comb begin
		ctl_s1          = '0;
		ctl_s1.in_range = (32'(atom_q[1]) < ATOM_COUNT);
		ctl_s1.kick     = (req_s1 == REQ_PHASE1) || (req_s1 == REQ_PHASE4);
		ctl_s1.friction = (req_s1 == REQ_PHASE2);
		ctl_s1.active   = ctl_s1.in_range && (m_s1 != '0) &&
			(req_s1 == REQ_PHASE1 || req_s1 == REQ_PHASE2 ||
			 req_s1 == REQ_PHASE3 || req_s1 == REQ_PHASE4);
		ctl_s1.load_v   = ctl_s1.in_range && (req_s1 == REQ_LOAD_VM);
		ctl_s1.load_p   = ctl_s1.in_range && (req_s1 == REQ_LOAD_POS);
		ctl_s1.upd_pos  = ctl_s1.active && (req_s1 == REQ_PHASE2 || req_s1 == REQ_PHASE3);
		ctl_s1.upd_delta = ctl_s1.active && (req_s1 == REQ_PHASE1 || req_s1 == REQ_PHASE2);
	end

	// Control and scalar pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			req_s1    <= s_tuser;
			atom_q[1] <= s_atom;
			for (int k = 2; k <= LAST_STAGE; k++) atom_q[k] <= atom_q[k-1];
			ctl_q[2]  <= ctl_s1;
			for (int k = 3; k <= LAST_STAGE; k++) ctl_q[k] <= ctl_q[k-1];
			hm_s2  <= 64'(cfg_q.half_step) * 64'(m_s1);
			amp_s6 <= 48'(cfg_q.noise_scale) * 48'(root_s5);
			amp_s7 <= amp_s6;
		end
	end

	baoab_isqrt u_isqrt (
		.clk (clk), .en (en), .x (m_s1), .root (root_s5)
	);

	assign wr_en = en && valid_q[LAST_STAGE] && ctl_q[LAST_STAGE].in_range;

	for (genvar g = 0; g < 3; g++) begin : g_lane
		baoab_lane u_lane (
			.clk     (clk),
			.en      (en),
			.rd_atom (s_atom[MEM_AW-1:0]),
			.vec_in  (vec_in[g]),
			.nz_in   (nz_in[g]),
			.ctl_s1  (ctl_s1),
			.ctl_s2  (ctl_q[2]),
			.ctl_s11 (ctl_q[11]),
			.ctl_s16 (ctl_q[LAST_STAGE]),
			.cfg     (cfg_q),
			.hm_s2   (hm_s2),
			.amp_s7  (amp_s7),
			.wr_en   (wr_en),
			.wr_atom (atom_q[LAST_STAGE][MEM_AW-1:0]),
			.vel_out (vel_o[g]),
			.pos_out (pos_o[g]),
			.dlt_out (dlt_o[g])
		);
	end

	// Merge the lanes into the output register
	always_ff @(posedge clk) begin
		if (en)
			m_tdata_q <= {6'b0, dlt_o[2], dlt_o[1], dlt_o[0], pos_o[2], pos_o[1], pos_o[0],
				vel_o[2], vel_o[1], vel_o[0], atom_q[LAST_STAGE]};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// An accepted item never reads an atom that is being written back
	a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && valid_q[LAST_STAGE]) |-> (s_atom != atom_q[LAST_STAGE]))
		else $error("accepted atom collides with write-back");

	// A result only appears after an item left the last stage
	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_q[LAST_STAGE]))
		else $error("result without a finished item");

	// An active phase only for atoms inside the table
	a_active_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q[LAST_STAGE] && ctl_q[LAST_STAGE].active) |-> ctl_q[LAST_STAGE].in_range)
		else $error("phase applied to atom outside the table");

endmodule
